FILE: design/brot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brot_pkg: shared types and constants for the 8x8 block rotation core
// Block size, coefficient format, item kind codes and the stage advance struct.
// ----------------------------------------------------------------------------
package brot_pkg;

	localparam int BLOCK          = 8;
	localparam int ROW_W          = $clog2(BLOCK);
	localparam int COEF_W         = 16;
	localparam int DATA_WIDTH_DEF = 16;
	localparam int COEF_FRAC_DEF  = 14;

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_DATA = 1'b1
	} kind_t;

	// per-stage advance enables, driven by the top level pipeline control
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} brot_adv_t;

	// accumulator width: full dot product plus rounding headroom,
	// and never narrower than the rounding shift needs
	function automatic int acc_width(input int dw, input int fb);
		int w;
		w = dw + COEF_W + 4;
		if (w < fb + 2) begin
			w = fb + 2;
		end
		return w;
	endfunction

endpackage

FILE: design/brot_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brot_lane: one output row of the rotation
// Eight products, a two-level adder tree and the rounding offset, three stages.
// ----------------------------------------------------------------------------
module brot_lane import brot_pkg::*; #(
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                                          clk,
	input  brot_adv_t                                     adv,
	input  logic signed [DATA_WIDTH-1:0]                  x      [BLOCK],
	input  logic signed [COEF_W-1:0]                      coef   [BLOCK],
	output logic signed [acc_width(DATA_WIDTH, COEF_FRAC_BITS)-1:0] acc_s3
);

	localparam int PW   = DATA_WIDTH + COEF_W;
	localparam int AW   = acc_width(DATA_WIDTH, COEF_FRAC_BITS);
	localparam int HALF = BLOCK / 2;
	localparam logic signed [AW-1:0] RND = AW'(1) << (COEF_FRAC_BITS - 1);

	logic signed [PW-1:0] prod_s1 [BLOCK];
	logic signed [AW-1:0] half_s2 [2];
	logic signed [AW-1:0] half_d  [2];

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			half_d[h] = '0;
			for (int c = 0; c < HALF; c++) begin
				half_d[h] = half_d[h] + AW'(prod_s1[h*HALF + c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			for (int c = 0; c < BLOCK; c++) begin
				prod_s1[c] <= PW'(x[c]) * PW'(coef[c]);
			end
		end
		if (adv.en_s2) begin
			half_s2 <= half_d;
		end
		if (adv.en_s3) begin
			acc_s3 <= half_s2[0] + half_s2[1] + RND;
		end
	end

endmodule

FILE: design/brot_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brot_merge: lane merge and output register
// Shift, clip each lane to the data width, OR the clip flags, hold the result.
// ----------------------------------------------------------------------------
module brot_merge import brot_pkg::*; #(
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                                                    clk,
	input  logic                                                    arst_n,
	input  logic                                                    load,
	input  logic                                                    item_valid,
	input  logic                                                    full,
	input  logic signed [acc_width(DATA_WIDTH, COEF_FRAC_BITS)-1:0] acc [BLOCK],
	input  logic signed [DATA_WIDTH-1:0]                            x   [BLOCK],
	output logic                                                    out_valid,
	output logic signed [DATA_WIDTH-1:0]                            rot [BLOCK],
	output logic                                                    saturated
);

	localparam int AW = acc_width(DATA_WIDTH, COEF_FRAC_BITS);
	localparam int HW = AW - DATA_WIDTH + 1;
	localparam logic signed [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic signed [AW-1:0]         sh    [BLOCK];
	logic [HW-1:0]                top_b [BLOCK];
	logic [BLOCK-1:0]             ovf;
	logic signed [DATA_WIDTH-1:0] val   [BLOCK];
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] rot_q [BLOCK];
	logic                         sat_q;

	always_comb begin
		for (int r = 0; r < BLOCK; r++) begin
			sh[r]    = acc[r] >>> COEF_FRAC_BITS;
			top_b[r] = sh[r][AW-1:DATA_WIDTH-1];
			ovf[r]   = !((&top_b[r]) || (~|top_b[r]));
			if (!full) begin
				val[r] = x[r];
			end else if (ovf[r]) begin
				val[r] = sh[r][AW-1] ? MINV : MAXV;
			end else begin
				val[r] = sh[r][DATA_WIDTH-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rot_q <= val;
			sat_q <= full & (|ovf);
		end
	end

	assign out_valid = out_valid_q;
	assign rot       = rot_q;
	assign saturated = sat_q;

endmodule

FILE: design/block_rotation_8x8_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_rotation_8x8_core: 8x8 fixed-point block rotation
// Stores an 8x8 coefficient matrix and multiplies each 8-element item by it.
// ----------------------------------------------------------------------------
// The core takes one item per clock unless in_stall is high and returns one
// result per data item accepted; load items (kind 0) write one matrix row of
// eight signed Q1.14 coefficients and produce nothing. Eight row lanes work
// side by side, each with eight multipliers, so a new data item can enter every
// cycle unless stalled; pipeline: products, half sums, full sum plus rounding,
// then shift/clip in the merge stage into the output register. Each output is
// the row dot product rounded to nearest (ties toward +inf) and clipped to the
// data width; saturated flags any clipped element. Until all eight rows have
// been loaded, data items come out unchanged with saturated low. Reloading a
// row takes effect for the next data item accepted after it. Stages with no
// item collapse, so input stall only rises when every stage holds an item and
// the output register is stalled. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module block_rotation_8x8_core import brot_pkg::*; #(
	parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         kind,
	input  logic [ROW_W-1:0]             row_index,
	input  logic signed [DATA_WIDTH-1:0] elem_0,
	input  logic signed [DATA_WIDTH-1:0] elem_1,
	input  logic signed [DATA_WIDTH-1:0] elem_2,
	input  logic signed [DATA_WIDTH-1:0] elem_3,
	input  logic signed [DATA_WIDTH-1:0] elem_4,
	input  logic signed [DATA_WIDTH-1:0] elem_5,
	input  logic signed [DATA_WIDTH-1:0] elem_6,
	input  logic signed [DATA_WIDTH-1:0] elem_7,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] rot_0,
	output logic signed [DATA_WIDTH-1:0] rot_1,
	output logic signed [DATA_WIDTH-1:0] rot_2,
	output logic signed [DATA_WIDTH-1:0] rot_3,
	output logic signed [DATA_WIDTH-1:0] rot_4,
	output logic signed [DATA_WIDTH-1:0] rot_5,
	output logic signed [DATA_WIDTH-1:0] rot_6,
	output logic signed [DATA_WIDTH-1:0] rot_7,
	output logic                         saturated
);

	localparam int AW = acc_width(DATA_WIDTH, COEF_FRAC_BITS);

	logic signed [DATA_WIDTH-1:0] elem    [BLOCK];
	logic signed [COEF_W-1:0]     coef_in [BLOCK];
	logic signed [COEF_W-1:0]     coef_q  [BLOCK][BLOCK];
	logic [BLOCK-1:0]             rows_loaded_q;
	logic                         matrix_full;

	// pipeline control
	brot_adv_t adv;
	logic      en_out;
	logic      in_acc;
	logic      load_acc;
	logic      data_acc;
	logic      v_s1, v_s2, v_s3;
	logic      full_s1, full_s2, full_s3;

	logic signed [DATA_WIDTH-1:0] x_s1 [BLOCK];
	logic signed [DATA_WIDTH-1:0] x_s2 [BLOCK];
	logic signed [DATA_WIDTH-1:0] x_s3 [BLOCK];
	logic signed [AW-1:0]         acc_s3 [BLOCK];
	logic signed [DATA_WIDTH-1:0] rot [BLOCK];

	assign elem[0] = elem_0;
	assign elem[1] = elem_1;
	assign elem[2] = elem_2;
	assign elem[3] = elem_3;
	assign elem[4] = elem_4;
	assign elem[5] = elem_5;
	assign elem[6] = elem_6;
	assign elem[7] = elem_7;

	// coefficient word from an element: low COEF_W bits, zero padded if narrower
	for (genvar c = 0; c < BLOCK; c++) begin : g_coef
		if (DATA_WIDTH >= COEF_W) begin : g_trunc
			assign coef_in[c] = elem[c][COEF_W-1:0];
		end else begin : g_pad
			assign coef_in[c] = {{(COEF_W-DATA_WIDTH){1'b0}}, elem[c]};
		end
	end

	// bubble-collapsing advance chain, output side first
	assign en_out     = !out_valid || !out_stall;
	assign adv.en_s3  = !v_s3 || en_out;
	assign adv.en_s2  = !v_s2 || adv.en_s3;
	assign adv.en_s1  = !v_s1 || adv.en_s2;
	assign in_stall   = !adv.en_s1;

	assign in_acc      = in_valid && !in_stall;
	assign load_acc    = in_acc && (kind == KIND_LOAD);
	assign data_acc    = in_acc && (kind == KIND_DATA);
	assign matrix_full = &rows_loaded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_loaded_q <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			v_s3          <= 1'b0;
		end else begin
			if (load_acc) begin
				rows_loaded_q[row_index] <= 1'b1;
			end
			if (adv.en_s1) begin
				v_s1 <= data_acc;
			end
			if (adv.en_s2) begin
				v_s2 <= v_s1;
			end
			if (adv.en_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// row store; lane r reads row r in place
	always_ff @(posedge clk) begin
		if (load_acc) begin
			for (int c = 0; c < BLOCK; c++) begin
				coef_q[row_index][c] <= coef_in[c];
			end
		end
	end

	// pass-through data and matrix state travel alongside the lanes
	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			x_s1    <= elem;
			full_s1 <= matrix_full;
		end
		if (adv.en_s2) begin
			x_s2    <= x_s1;
			full_s2 <= full_s1;
		end
		if (adv.en_s3) begin
			x_s3    <= x_s2;
			full_s3 <= full_s2;
		end
	end

	for (genvar r = 0; r < BLOCK; r++) begin : g_lane
		brot_lane #(
			.DATA_WIDTH     (DATA_WIDTH),
			.COEF_FRAC_BITS (COEF_FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.adv    (adv),
			.x      (elem),
			.coef   (coef_q[r]),
			.acc_s3 (acc_s3[r])
		);
	end

	brot_merge #(
		.DATA_WIDTH     (DATA_WIDTH),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (en_out),
		.item_valid (v_s3),
		.full       (full_s3),
		.acc        (acc_s3),
		.x          (x_s3),
		.out_valid  (out_valid),
		.rot        (rot),
		.saturated  (saturated)
	);

	assign rot_0 = rot[0];
	assign rot_1 = rot[1];
	assign rot_2 = rot[2];
	assign rot_3 = rot[3];
	assign rot_4 = rot[4];
	assign rot_5 = rot[5];
	assign rot_6 = rot[6];
	assign rot_7 = rot[7];

	// a load item never enters the result pipeline
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		load_acc |=> !v_s1)
		else $error("load item entered result pipeline");

	// loaded rows are never forgotten
	a_rows_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((rows_loaded_q & $past(rows_loaded_q)) == $past(rows_loaded_q)))
		else $error("row loaded flag cleared");

	// input only stalls when every stage is occupied and the output is held
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid && out_stall))
		else $error("input stalled with a free stage");

	// a pass-through result never reports clipping
	a_pass_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(en_out && v_s3 && !full_s3) |=> !saturated)
		else $error("saturation flagged on pass-through item");

endmodule
